@@ design/qzcf_pkg.sv @@
// ----------------------------------------------------------------------------
// qzcf_pkg
// Shared types, constants and the segment judging function for the
// qualified zero-crossing filter.
// ----------------------------------------------------------------------------
package qzcf_pkg;

	// payload widths
	localparam int SAMPLE_W = 19;
	localparam int POS_W    = 12;
	localparam int COUNT_W  = 13;
	localparam int DZ_W     = 10;
	localparam int MDEV_W   = 30;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 30;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DEV   = 1'd1;
	localparam logic [DZ_W-1:0]      DEAD_ZONE_RST = 10'd1;
	localparam logic [MDEV_W-1:0]    MIN_DEV_RST   = 30'd3072;

	// window length default
	localparam int MAX_WINDOW_DEF = 4096;

	// result queue: one item pushes at most three beats
	localparam int PUSH_MAX    = 3;
	localparam int PUSH_IDX_W  = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W      = 3;

	// held sign codes
	localparam logic [1:0] SIGN_NONE = 2'd0;
	localparam logic [1:0] SIGN_POS  = 2'd1;
	localparam logic [1:0] SIGN_NEG  = 2'd2;

	typedef enum logic [2:0] {
		PH_SEEK  = 3'b001,
		PH_JUDGE = 3'b010,
		PH_SKIP  = 3'b100
	} phase_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} in_t;

	typedef struct packed {
		logic               is_summary;
		logic [POS_W-1:0]   crossing_pos;
		logic [COUNT_W-1:0] kept_count;
		logic               end_of_run;
	} out_t;

	typedef struct packed {
		logic [DZ_W-1:0]   dead_zone;
		logic [MDEV_W-1:0] min_deviation;
	} cfg_t;

	// beats pushed by one item, packed from entry 0
	typedef struct packed {
		logic [PUSH_IDX_W-1:0]   n;
		out_t [PUSH_MAX-1:0]     ent;
	} push_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              room;
	} qstat_t;

	typedef struct packed {
		phase_t nxt;
		logic   keep;
	} judge_t;

	// phase step for a closing segment; unknown codes act as seeking
	function automatic judge_t judge(phase_t ph, logic ok);
		judge_t r;
		r.keep = 1'b0;
		r.nxt  = ph;
		case (ph)
			PH_JUDGE: begin
				if (ok) r.keep = 1'b1;
				else    r.nxt  = PH_SKIP;
			end
			PH_SKIP: begin
				r.nxt = PH_JUDGE;
			end
			default: begin
				r.nxt = ok ? PH_JUDGE : PH_SEEK;
			end
		endcase
		return r;
	endfunction

endpackage

@@ design/qualified_zero_crossing_filter_unit.sv @@
// ----------------------------------------------------------------------------
// qualified_zero_crossing_filter_unit: registered input stage, then a registered result queue
// one sample per cycle while in_stall is low; a stall holds it until the queue has room
// async active-low reset clears window state, queue and config (dead zone 1, min dev 3072)
// ----------------------------------------------------------------------------
module qualified_zero_crossing_filter_unit #(
	parameter int MAX_WINDOW = qzcf_pkg::MAX_WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  qzcf_pkg::in_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output qzcf_pkg::out_t                    out_data,
	input  logic                              cfg_we,
	input  logic [qzcf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qzcf_pkg::CFG_DATA_W-1:0]   cfg_data
);

	qzcf_pkg::cfg_t   cfg_q;
	qzcf_pkg::in_t    item_s1;
	logic             valid_s1;
	logic             go;
	qzcf_pkg::push_t  push;
	qzcf_pkg::qstat_t qstat;

	// item moves on when the queue can take all its beats
	assign go       = valid_s1 && qstat.room;
	assign in_stall = valid_s1 && !qstat.room;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dead_zone     <= qzcf_pkg::DEAD_ZONE_RST;
			cfg_q.min_deviation <= qzcf_pkg::MIN_DEV_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				qzcf_pkg::REG_DEAD_ZONE: cfg_q.dead_zone <= cfg_data[qzcf_pkg::DZ_W-1:0];
				qzcf_pkg::REG_MIN_DEV:   cfg_q.min_deviation <= cfg_data[qzcf_pkg::MDEV_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) item_s1 <= in_data;
	end

	qzcf_core #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.item_s1 (item_s1),
		.cfg     (cfg_q),
		.push    (push)
	);

	qzcf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.stat      (qstat)
	);

`ifndef SYNTH
	// queue never overfills
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= qzcf_pkg::QCNT_W'(qzcf_pkg::QUEUE_DEPTH))
		else $error("result queue overfilled");

	// a held sample stays in the input register unchanged
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !go |=> valid_s1 && $stable(item_s1))
		else $error("held sample lost or changed");

	// no beats pushed without a sample moving
	a_push_go: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != '0 |-> go)
		else $error("beats pushed without a sample");
`endif

endmodule

@@ design/qzcf_core.sv @@
// ----------------------------------------------------------------------------
// qzcf_core
// Window state and single-pass segment logic: sign with dead zone, crossing
// detect, segment sum, judging, and the beats each item produces.
// ----------------------------------------------------------------------------
module qzcf_core #(
	parameter int MAX_WINDOW = qzcf_pkg::MAX_WINDOW_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  qzcf_pkg::in_t   item_s1,
	input  qzcf_pkg::cfg_t  cfg,
	output qzcf_pkg::push_t push
);

	localparam int START_W = $clog2(MAX_WINDOW);
	localparam int IDX_W   = START_W + 1;
	localparam int SUM_W   = START_W + qzcf_pkg::SAMPLE_W + 1;
	localparam int CMP_W   = (SUM_W > qzcf_pkg::MDEV_W) ? SUM_W : qzcf_pkg::MDEV_W;
	localparam int EXT_W   = (START_W > qzcf_pkg::POS_W) ? START_W : qzcf_pkg::POS_W;

	logic [1:0]               held_sign_q;
	logic signed [SUM_W-1:0]  segment_sum_q;
	logic [IDX_W-1:0]         sample_index_q;
	qzcf_pkg::phase_t         phase_q;
	logic [START_W-1:0]       segment_start_q;
	logic [qzcf_pkg::COUNT_W-1:0] kept_total_q;
	logic                     seen_q;

	logic                     idx_ok;
	logic signed [qzcf_pkg::SAMPLE_W:0] val_w;
	logic signed [qzcf_pkg::SAMPLE_W:0] dz_w;
	logic                     sg_pos, sg_neg;
	logic [1:0]               sg;
	logic                     crossing;
	logic signed [SUM_W-1:0]  val_ext;
	logic [SUM_W-1:0]         mag_old, mag_new;
	logic                     ok_old, ok_new;
	qzcf_pkg::judge_t         j1, j2;
	qzcf_pkg::phase_t         phase_a, phase_b;
	logic                     emit1, emit2;
	logic [qzcf_pkg::COUNT_W-1:0] kept_a, kept_b;
	logic [START_W-1:0]       start_a;
	logic signed [SUM_W-1:0]  sum_a;
	logic                     seen_a;
	logic [1:0]               held_a;
	logic [EXT_W-1:0]         pos_old_ext, pos_a_ext;
	qzcf_pkg::out_t           r1, r2, r3;

	// sign with dead zone
	always_comb begin
		idx_ok  = sample_index_q < IDX_W'(MAX_WINDOW);
		val_w   = (qzcf_pkg::SAMPLE_W+1)'(item_s1.sample);
		dz_w    = signed'({{(qzcf_pkg::SAMPLE_W+1-qzcf_pkg::DZ_W){1'b0}}, cfg.dead_zone});
		sg_pos  = val_w > dz_w;
		sg_neg  = val_w < -dz_w;
		sg      = sg_pos ? qzcf_pkg::SIGN_POS :
			  sg_neg ? qzcf_pkg::SIGN_NEG : qzcf_pkg::SIGN_NONE;
		crossing = idx_ok && (sg != qzcf_pkg::SIGN_NONE) &&
			   (held_sign_q != qzcf_pkg::SIGN_NONE) && (sg != held_sign_q);
		val_ext = SUM_W'(item_s1.sample);
	end

	// judge the segment closed by a crossing, using the old sum
	always_comb begin
		mag_old = segment_sum_q[SUM_W-1] ? SUM_W'(-segment_sum_q) : SUM_W'(segment_sum_q);
		ok_old  = CMP_W'(mag_old) >= CMP_W'(cfg.min_deviation);
		j1      = qzcf_pkg::judge(phase_q, ok_old);
		phase_a = crossing ? j1.nxt : phase_q;
		emit1   = crossing && j1.keep;
		kept_a  = kept_total_q + qzcf_pkg::COUNT_W'(emit1);
		start_a = crossing ? sample_index_q[START_W-1:0] : segment_start_q;
		seen_a  = seen_q || crossing;
		held_a  = (idx_ok && sg != qzcf_pkg::SIGN_NONE) ? sg : held_sign_q;
		if (idx_ok) sum_a = (crossing ? '0 : segment_sum_q) + val_ext;
		else        sum_a = segment_sum_q;
	end

	// final segment judge on the last sample
	always_comb begin
		mag_new = sum_a[SUM_W-1] ? SUM_W'(-sum_a) : SUM_W'(sum_a);
		ok_new  = CMP_W'(mag_new) >= CMP_W'(cfg.min_deviation);
		j2      = qzcf_pkg::judge(phase_a, ok_new);
		emit2   = item_s1.last && seen_a && j2.keep;
		phase_b = (item_s1.last && seen_a) ? j2.nxt : phase_a;
		kept_b  = kept_a + qzcf_pkg::COUNT_W'(emit2);
	end

	// build the beats in order and pack them from entry 0
	always_comb begin
		pos_old_ext = EXT_W'(segment_start_q);
		pos_a_ext   = EXT_W'(start_a);
		r1.is_summary   = 1'b0;
		r1.crossing_pos = pos_old_ext[qzcf_pkg::POS_W-1:0];
		r1.kept_count   = kept_a;
		r1.end_of_run   = !item_s1.last;
		r2.is_summary   = 1'b0;
		r2.crossing_pos = pos_a_ext[qzcf_pkg::POS_W-1:0];
		r2.kept_count   = kept_b;
		r2.end_of_run   = 1'b0;
		r3.is_summary   = 1'b1;
		r3.crossing_pos = '0;
		r3.kept_count   = kept_b;
		r3.end_of_run   = 1'b1;
		push.n   = '0;
		push.ent = '0;
		if (go && emit1) begin
			push.ent[push.n] = r1;
			push.n = push.n + 2'd1;
		end
		if (go && emit2) begin
			push.ent[push.n] = r2;
			push.n = push.n + 2'd1;
		end
		if (go && item_s1.last) begin
			push.ent[push.n] = r3;
			push.n = push.n + 2'd1;
		end
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_sign_q     <= qzcf_pkg::SIGN_NONE;
			segment_sum_q   <= '0;
			sample_index_q  <= '0;
			phase_q         <= qzcf_pkg::PH_SEEK;
			segment_start_q <= '0;
			kept_total_q    <= '0;
			seen_q          <= 1'b0;
		end else if (go) begin
			if (item_s1.last) begin
				held_sign_q     <= qzcf_pkg::SIGN_NONE;
				segment_sum_q   <= '0;
				sample_index_q  <= '0;
				phase_q         <= qzcf_pkg::PH_SEEK;
				segment_start_q <= '0;
				kept_total_q    <= '0;
				seen_q          <= 1'b0;
			end else begin
				held_sign_q     <= held_a;
				segment_sum_q   <= sum_a;
				sample_index_q  <= sample_index_q + IDX_W'(idx_ok);
				phase_q         <= phase_b;
				segment_start_q <= start_a;
				kept_total_q    <= kept_b;
				seen_q          <= seen_a;
			end
		end
	end

endmodule

@@ design/qzcf_outq.sv @@
// ----------------------------------------------------------------------------
// qzcf_outq
// Small result queue: takes up to three beats per cycle, gives one beat per
// cycle on the output channel while out_stall is low.
// ----------------------------------------------------------------------------
module qzcf_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  qzcf_pkg::push_t  push,
	output logic             out_valid,
	input  logic             out_stall,
	output qzcf_pkg::out_t   out_data,
	output qzcf_pkg::qstat_t stat
);

	qzcf_pkg::out_t              ent_q [qzcf_pkg::QUEUE_DEPTH];
	qzcf_pkg::out_t              ent_nxt [qzcf_pkg::QUEUE_DEPTH];
	logic [qzcf_pkg::QCNT_W-1:0] count_q;
	logic [qzcf_pkg::QCNT_W-1:0] base;
	logic [qzcf_pkg::QCNT_W-1:0] k;
	logic                        pop;

	assign out_valid  = count_q != '0;
	assign out_data   = ent_q[0];
	assign pop        = out_valid && !out_stall;
	assign base       = count_q - qzcf_pkg::QCNT_W'(pop);
	assign stat.count = count_q;
	assign stat.room  = base <= qzcf_pkg::QCNT_W'(qzcf_pkg::QUEUE_DEPTH - qzcf_pkg::PUSH_MAX);

	// shift out on pop, then append the new beats
	always_comb begin
		k = '0;
		for (int i = 0; i < qzcf_pkg::QUEUE_DEPTH; i++) begin
			if (pop && i < qzcf_pkg::QUEUE_DEPTH - 1) ent_nxt[i] = ent_q[i+1];
			else                                      ent_nxt[i] = ent_q[i];
			k = qzcf_pkg::QCNT_W'(i) - base;
			if (qzcf_pkg::QCNT_W'(i) >= base && k < qzcf_pkg::QCNT_W'(push.n))
				ent_nxt[i] = push.ent[k[qzcf_pkg::PUSH_IDX_W-1:0]];
		end
	end

	// beat storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < qzcf_pkg::QUEUE_DEPTH; i++) ent_q[i] <= ent_nxt[i];
	end

	// fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= base + qzcf_pkg::QCNT_W'(push.n);
		end
	end

endmodule
